/* sv/slx_pkg.sv */
package slx_pkg;

  localparam int LINE_OUT_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_N   = 8'h6e;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_UNDER     = 8'h5f;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;

  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_PUNCT  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_ERROR
  } mode_t;

  typedef struct packed {
    logic alpha;      // letter or underscore
    logic digit;
    logic dot;
    logic quote;
    logic backslash;
    logic blank;      // space or tab
    logic newline;    // CR or LF
    logic punct;
    logic lower_r;
    logic lower_n;
  } char_class_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [7:0]            ch;
    logic                  valid;
    logic                  first;
    logic                  last;
    logic [LINE_OUT_W-1:0] line;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_out_t;

endpackage

/* sv/slx_class.sv */
module slx_class (
  input  logic [7:0]           ch,
  output slx_pkg::char_class_t cls
);

  always_comb begin
    cls           = '0;
    cls.alpha     = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) ||
                    (ch == slx_pkg::CH_UNDER);
    cls.digit     = (ch >= 8'h30 && ch <= 8'h39);
    cls.dot       = (ch == slx_pkg::CH_DOT);
    cls.quote     = (ch == slx_pkg::CH_QUOTE);
    cls.backslash = (ch == slx_pkg::CH_BACKSLASH);
    cls.blank     = (ch == slx_pkg::CH_SPACE) || (ch == slx_pkg::CH_TAB);
    cls.newline   = (ch == slx_pkg::CH_CR) || (ch == slx_pkg::CH_LF);
    cls.lower_r   = (ch == slx_pkg::CH_LOWER_R);
    cls.lower_n   = (ch == slx_pkg::CH_LOWER_N);
    unique case (ch) inside
      8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h25, 8'h3d, 8'h28, 8'h29, 8'h7b,
      8'h7d, 8'h3e, 8'h3c, 8'h2c, 8'h24, 8'h3a, 8'h5b, 8'h5d, 8'h3b: cls.punct = 1'b1;
      default: cls.punct = 1'b0;
    endcase
  end

endmodule

/* sv/slx_core.sv */
module slx_core #(
  parameter int LINE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_input,
  output slx_pkg::step_out_t   step
);

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  slx_pkg::mode_t          mode, mode_next;
  logic [7:0]              held_char, held_char_next;
  logic                    held_valid, held_valid_next;
  logic                    held_first, held_first_next;
  logic [LINE_BITS-1:0]    tok_line, tok_line_next;
  logic [LINE_BITS-1:0]    line_count, line_count_next;

  slx_pkg::char_class_t    cls;
  slx_pkg::mode_t          idle_target;
  slx_pkg::result_t        res_a, res_b, held_res;
  logic                    a_v, b_v, do_idle;
  logic [7:0]              str_char;
  logic [slx_pkg::LINE_OUT_W-1:0] tok16, line16;

  slx_class u_class (
    .ch  (in_byte),
    .cls (cls)
  );

  assign tok16    = (slx_pkg::LINE_OUT_W)'(tok_line);
  assign line16   = (slx_pkg::LINE_OUT_W)'(line_count);
  assign str_char = (mode == slx_pkg::MODE_ESCAPE) ?
                    (cls.lower_r ? slx_pkg::CH_CR : slx_pkg::CH_LF) : in_byte;

  always_comb begin
    if (cls.alpha)
      idle_target = slx_pkg::MODE_IDENT;
    else if (cls.digit || cls.dot)
      idle_target = slx_pkg::MODE_NUMBER;
    else if (cls.quote)
      idle_target = slx_pkg::MODE_STRING;
    else if (cls.blank || cls.newline || cls.punct)
      idle_target = slx_pkg::MODE_IDLE;
    else
      idle_target = slx_pkg::MODE_ERROR;
  end

  // next mode
  always_comb begin
    mode_next = mode;
    if (end_of_input) begin
      mode_next = slx_pkg::MODE_IDLE;
    end else begin
      unique case (mode)
        slx_pkg::MODE_IDENT:  mode_next = (cls.alpha || cls.digit) ? mode : idle_target;
        slx_pkg::MODE_NUMBER: mode_next = (cls.digit || cls.dot) ? mode : idle_target;
        slx_pkg::MODE_STRING: begin
          if (cls.quote)
            mode_next = slx_pkg::MODE_IDLE;
          else if (cls.backslash)
            mode_next = slx_pkg::MODE_ESCAPE;
        end
        slx_pkg::MODE_ESCAPE: mode_next = (cls.lower_r || cls.lower_n) ?
                                          slx_pkg::MODE_STRING : slx_pkg::MODE_ERROR;
        slx_pkg::MODE_ERROR:  mode_next = slx_pkg::MODE_ERROR;
        slx_pkg::MODE_IDLE:   mode_next = idle_target;
        default:              mode_next = slx_pkg::MODE_IDLE;
      endcase
    end
  end

  // results and data state; slot a is the held character (or an empty string),
  // slot b a punctuation, end or error token, which always comes after it
  always_comb begin
    held_res.kind  = (mode == slx_pkg::MODE_IDENT)  ? slx_pkg::KIND_IDENT :
                     (mode == slx_pkg::MODE_NUMBER) ? slx_pkg::KIND_NUMBER :
                                                      slx_pkg::KIND_STRING;
    held_res.ch    = held_char;
    held_res.valid = 1'b1;
    held_res.first = held_first;
    held_res.last  = 1'b0;
    held_res.line  = tok16;

    res_a           = held_res;
    a_v             = 1'b0;
    res_b.kind      = slx_pkg::KIND_END;
    res_b.ch        = 8'h00;
    res_b.valid     = 1'b0;
    res_b.first     = 1'b1;
    res_b.last      = 1'b1;
    res_b.line      = line16;
    b_v             = 1'b0;
    do_idle         = 1'b0;
    held_char_next  = held_char;
    held_valid_next = held_valid;
    held_first_next = held_first;
    tok_line_next   = tok_line;
    line_count_next = line_count;

    if (end_of_input) begin
      unique case (mode) inside
        slx_pkg::MODE_IDENT, slx_pkg::MODE_NUMBER: begin
          a_v        = held_valid;
          res_a.last = 1'b1;
          b_v        = 1'b1;
        end
        slx_pkg::MODE_STRING: begin
          a_v        = 1'b1;
          res_a.last = 1'b1;
          if (!held_valid) begin
            res_a.ch    = 8'h00;
            res_a.valid = 1'b0;
            res_a.first = 1'b1;
          end
          b_v = 1'b1;
        end
        slx_pkg::MODE_ESCAPE: begin
          b_v        = 1'b1;
          res_b.kind = slx_pkg::KIND_ERROR;
        end
        slx_pkg::MODE_ERROR: ;
        default: b_v = 1'b1;
      endcase
      held_char_next  = 8'h00;
      held_valid_next = 1'b0;
      held_first_next = 1'b0;
      tok_line_next   = LINE_ONE;
      line_count_next = LINE_ONE;
    end else begin
      unique case (mode) inside
        slx_pkg::MODE_IDENT, slx_pkg::MODE_NUMBER: begin
          a_v = held_valid;
          if ((mode == slx_pkg::MODE_IDENT) ? (cls.alpha || cls.digit) :
              (cls.digit || cls.dot)) begin
            held_char_next  = in_byte;
            held_valid_next = 1'b1;
            held_first_next = 1'b0;
          end else begin
            res_a.last      = 1'b1;
            held_valid_next = 1'b0;
            do_idle         = 1'b1;
          end
        end
        slx_pkg::MODE_STRING, slx_pkg::MODE_ESCAPE: begin
          if (mode == slx_pkg::MODE_STRING && cls.quote) begin
            a_v        = 1'b1;
            res_a.last = 1'b1;
            if (!held_valid) begin
              res_a.ch    = 8'h00;
              res_a.valid = 1'b0;
              res_a.first = 1'b1;
            end
            held_valid_next = 1'b0;
          end else if (mode == slx_pkg::MODE_STRING && cls.backslash) begin
            a_v = 1'b0;
          end else if (mode == slx_pkg::MODE_STRING || cls.lower_r || cls.lower_n) begin
            a_v             = held_valid;
            held_char_next  = str_char;
            held_valid_next = 1'b1;
            held_first_next = !held_valid;
          end else begin
            // unknown escape
            b_v             = 1'b1;
            res_b.kind      = slx_pkg::KIND_ERROR;
            held_char_next  = 8'h00;
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
          end
        end
        slx_pkg::MODE_ERROR: ;
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        if (cls.alpha || cls.digit || cls.dot) begin
          tok_line_next   = line_count;
          held_char_next  = in_byte;
          held_valid_next = 1'b1;
          held_first_next = 1'b1;
        end else if (cls.quote) begin
          tok_line_next   = line_count;
          held_valid_next = 1'b0;
          held_first_next = 1'b0;
        end else if (cls.blank) begin
          held_valid_next = held_valid_next;
        end else if (cls.newline) begin
          if (line_count != LINE_MAX)
            line_count_next = line_count + LINE_ONE;
        end else if (cls.punct) begin
          b_v         = 1'b1;
          res_b.kind  = slx_pkg::KIND_PUNCT;
          res_b.ch    = in_byte;
          res_b.valid = 1'b1;
        end else begin
          b_v             = 1'b1;
          res_b.kind      = slx_pkg::KIND_ERROR;
          held_char_next  = 8'h00;
          held_valid_next = 1'b0;
          held_first_next = 1'b0;
        end
      end
    end

    step.count = {1'b0, a_v} + {1'b0, b_v};
    step.r0    = a_v ? res_a : res_b;
    step.r1    = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= slx_pkg::MODE_IDLE;
      held_char  <= 8'h00;
      held_valid <= 1'b0;
      held_first <= 1'b0;
      tok_line   <= LINE_ONE;
      line_count <= LINE_ONE;
    end else if (fire) begin
      mode       <= mode_next;
      held_char  <= held_char_next;
      held_valid <= held_valid_next;
      held_first <= held_first_next;
      tok_line   <= tok_line_next;
      line_count <= line_count_next;
    end
  end

  a_eoi_resets: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_input |=> line_count == LINE_ONE && mode == slx_pkg::MODE_IDLE)
    else $error("end of input did not return the lexer to idle");

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    fire && !end_of_input && mode == slx_pkg::MODE_ERROR |-> step.count == 2'd0)
    else $error("result produced while in error");

  a_held_mode: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> mode == slx_pkg::MODE_IDENT || mode == slx_pkg::MODE_NUMBER ||
                   mode == slx_pkg::MODE_STRING || mode == slx_pkg::MODE_ESCAPE)
    else $error("held character outside a token");

endmodule

/* sv/slx_outq.sv */
module slx_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_en,
  input  slx_pkg::step_out_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output slx_pkg::result_t   out_res
);

  slx_pkg::result_t                mem [slx_pkg::QUEUE_DEPTH];
  logic [slx_pkg::QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [slx_pkg::QCNT_W-1:0]      count;
  logic [1:0]                      push_n;
  logic                            pop;

  assign push_n    = push_en ? push.count : 2'd0;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (slx_pkg::QCNT_W)'(slx_pkg::QUEUE_DEPTH - 2));
  assign out_res   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0)
      mem[wr_ptr] <= push.r0;
    if (push_n == 2'd2)
      mem[wr_ptr + (slx_pkg::QPTR_W)'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + (slx_pkg::QPTR_W)'(push_n);
      rd_ptr <= rd_ptr + (slx_pkg::QPTR_W)'(pop);
      count  <= count + (slx_pkg::QCNT_W)'(push_n) - (slx_pkg::QCNT_W)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (slx_pkg::QCNT_W)'(slx_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_pair_room: assert property (@(posedge clk) disable iff (rst)
    push_n == 2'd2 |-> count <= (slx_pkg::QCNT_W)'(slx_pkg::QUEUE_DEPTH - 2))
    else $error("two results pushed without room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && count == (slx_pkg::QCNT_W)'(1) && push_n == 2'd0 |=> !out_valid)
    else $error("queue not empty after last transfer");

endmodule

/* sv/source_text_lexer.sv */
// channel | dir | tdata                         | tuser         | tlast
// s_*     | in  | [7:0] in_byte                 | -             | end_of_input
// m_*     | out | [7:0] char_value, [8] valid,  | [2:0] kind    | last_of_token
//         |     | [9] first, [25:10] start_line |               |
//
// One byte is taken per cycle while s_tready is high; it produces zero, one or
// two results in the same cycle, written into a 4-entry result queue.
// A byte is accepted while the queue has room for two results; the queue hands
// its results to the output side one at a time.
// Synchronous reset clears the lexer state and empties the queue.
// Output stalls back up into s_tready once the queue holds more than two.
module source_text_lexer #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] char_value, [8] char_valid,
                                 // [9] first_of_token, [25:10] start_line
  output logic [2:0]  m_tuser,   // [2:0] token_kind
  output logic        m_tlast    // last_of_token
);

  slx_pkg::step_out_t step;
  slx_pkg::result_t   head;
  logic               room;
  logic               fire;

  assign s_tready = room;
  assign fire     = s_tvalid && room;

  slx_core #(
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .in_byte      (s_tdata),
    .end_of_input (s_tlast),
    .step         (step)
  );

  slx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (fire),
    .push      (step),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head)
  );

  assign m_tdata = {6'b0, head.line, head.first, head.valid, head.ch};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the token stream from the accepted bytes and holds the results
  // still owed by the lexer, oldest first.
  class token_checker;
    slx_pkg::mode_t   mode;
    logic [7:0]       held_ch;
    bit               held_v;
    bit               held_first;
    logic [15:0]      tok_line;
    logic [15:0]      line_cnt;
    slx_pkg::result_t pending[$];
    int               errors;
    int               live_items;
    int               texts;
    int               kind_seen[6];

    function new();
      clear_state();
    endfunction

    function void clear_state();
      mode       = slx_pkg::MODE_IDLE;
      held_ch    = 8'h00;
      held_v     = 1'b0;
      held_first = 1'b0;
      tok_line   = 16'd1;
      line_cnt   = 16'd1;
    endfunction

    function bit is_word_start(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == slx_pkg::CH_UNDER;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_number_char(logic [7:0] c);
      return is_digit(c) || c == slx_pkg::CH_DOT;
    endfunction

    function bit is_punct(logic [7:0] c);
      case (c)
        "+", "-", "*", "/", "%", "=", "(", ")", "{", "}", ">", "<", ",", "$", ":",
        "[", "]", ";": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit is_known(logic [7:0] c);
      return is_word_start(c) || is_number_char(c) || is_punct(c) ||
             c == slx_pkg::CH_QUOTE || c == slx_pkg::CH_SPACE || c == slx_pkg::CH_TAB ||
             c == slx_pkg::CH_CR || c == slx_pkg::CH_LF;
    endfunction

    function void push(logic [2:0] kind, logic [7:0] ch, bit valid, bit first, bit last,
                       logic [15:0] line);
      slx_pkg::result_t r;
      r.kind  = kind;
      r.ch    = ch;
      r.valid = valid;
      r.first = first;
      r.last  = last;
      r.line  = line;
      pending.push_back(r);
    endfunction

    function void push_held(bit last);
      logic [2:0] kind;
      kind = (mode == slx_pkg::MODE_IDENT) ? slx_pkg::KIND_IDENT :
             (mode == slx_pkg::MODE_NUMBER) ? slx_pkg::KIND_NUMBER : slx_pkg::KIND_STRING;
      if (held_v)
        push(kind, held_ch, 1'b1, held_first, last, tok_line);
    endfunction

    function void hold_ch(logic [7:0] c, bit first);
      held_ch    = c;
      held_v     = 1'b1;
      held_first = first;
    endfunction

    function void add_string_char(logic [7:0] c);
      if (held_v) begin
        push_held(1'b0);
        hold_ch(c, 1'b0);
      end else begin
        hold_ch(c, 1'b1);
      end
    endfunction

    // closing quote or end of text: an empty string still gives one result
    function void close_string();
      if (held_v)
        push_held(1'b1);
      else
        push(slx_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, tok_line);
    endfunction

    function void raise_error();
      push(slx_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1, line_cnt);
      mode       = slx_pkg::MODE_ERROR;
      held_v     = 1'b0;
      held_ch    = 8'h00;
      held_first = 1'b0;
    endfunction

    function void start_byte(logic [7:0] c);
      if (is_word_start(c)) begin
        mode     = slx_pkg::MODE_IDENT;
        tok_line = line_cnt;
        hold_ch(c, 1'b1);
      end else if (is_number_char(c)) begin
        mode     = slx_pkg::MODE_NUMBER;
        tok_line = line_cnt;
        hold_ch(c, 1'b1);
      end else if (c == slx_pkg::CH_QUOTE) begin
        mode       = slx_pkg::MODE_STRING;
        tok_line   = line_cnt;
        held_v     = 1'b0;
        held_first = 1'b0;
      end else if (c == slx_pkg::CH_SPACE || c == slx_pkg::CH_TAB) begin
      end else if (c == slx_pkg::CH_CR || c == slx_pkg::CH_LF) begin
        if (line_cnt != 16'hffff)
          line_cnt++;
      end else if (is_punct(c)) begin
        push(slx_pkg::KIND_PUNCT, c, 1'b1, 1'b1, 1'b1, line_cnt);
      end else begin
        raise_error();
      end
    endfunction

    // the byte that ends a word or number is then taken as a fresh start
    function void end_word(logic [7:0] c);
      push_held(1'b1);
      mode   = slx_pkg::MODE_IDLE;
      held_v = 1'b0;
      start_byte(c);
    endfunction

    function void note_input(logic [7:0] c, bit eoi);
      if (mode != slx_pkg::MODE_ERROR || eoi)
        live_items++;
      if (eoi) begin
        texts++;
        case (mode)
          slx_pkg::MODE_IDENT, slx_pkg::MODE_NUMBER: begin
            push_held(1'b1);
            push(slx_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, line_cnt);
          end
          slx_pkg::MODE_STRING: begin
            close_string();
            push(slx_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, line_cnt);
          end
          slx_pkg::MODE_ESCAPE:
            push(slx_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1, line_cnt);
          slx_pkg::MODE_ERROR: ;
          default: push(slx_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, line_cnt);
        endcase
        clear_state();
        return;
      end
      case (mode)
        slx_pkg::MODE_IDENT: begin
          if (is_word_start(c) || is_digit(c)) begin
            push_held(1'b0);
            hold_ch(c, 1'b0);
          end else begin
            end_word(c);
          end
        end
        slx_pkg::MODE_NUMBER: begin
          if (is_number_char(c)) begin
            push_held(1'b0);
            hold_ch(c, 1'b0);
          end else begin
            end_word(c);
          end
        end
        slx_pkg::MODE_STRING: begin
          if (c == slx_pkg::CH_QUOTE) begin
            close_string();
            mode   = slx_pkg::MODE_IDLE;
            held_v = 1'b0;
          end else if (c == slx_pkg::CH_BACKSLASH) begin
            mode = slx_pkg::MODE_ESCAPE;
          end else begin
            add_string_char(c);
          end
        end
        slx_pkg::MODE_ESCAPE: begin
          if (c == slx_pkg::CH_LOWER_R) begin
            mode = slx_pkg::MODE_STRING;
            add_string_char(slx_pkg::CH_CR);
          end else if (c == slx_pkg::CH_LOWER_N) begin
            mode = slx_pkg::MODE_STRING;
            add_string_char(slx_pkg::CH_LF);
          end else begin
            raise_error();
          end
        end
        slx_pkg::MODE_ERROR: ;
        default: begin
          mode = slx_pkg::MODE_IDLE;
          start_byte(c);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
      end
    endfunction

    function void check_result(slx_pkg::result_t got);
      slx_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual kind %0d char %h",
                 $time, got.kind, got.ch);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.kind < 6)
        kind_seen[exp_r.kind]++;
      compare_field("token_kind", 16'(exp_r.kind), 16'(got.kind));
      compare_field("char_value", 16'(exp_r.ch), 16'(got.ch));
      compare_field("char_valid", 16'(exp_r.valid), 16'(got.valid));
      compare_field("first_of_token", 16'(exp_r.first), 16'(got.first));
      compare_field("last_of_token", 16'(exp_r.last), 16'(got.last));
      compare_field("start_line", exp_r.line, got.line);
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;
  logic [2:0]       m_tuser;
  logic             m_tlast;
  slx_pkg::result_t observed;

  token_checker board = new();
  int          burst_left = 0;

  source_text_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign observed = {m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9], m_tlast, m_tdata[25:10]};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // both channels sampled at the edge, input side first
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        board.note_input(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        board.check_result(observed);
    end
  end

  // receiver: switches between stall styles at random intervals
  initial begin
    int style;
    int tick;
    tick = 0;
    forever begin
      style = $urandom_range(0, 3);
      repeat ($urandom_range(16, 96)) begin
        @(posedge clk);
        tick++;
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  task automatic send(input logic [7:0] b, input bit eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [7:0] pick_word_char(bit allow_digit);
    int i;
    i = $urandom_range(0, allow_digit ? 62 : 52);
    if (i < 26) return 8'("a" + i);
    if (i < 52) return 8'("A" + (i - 26));
    if (i == 52) return slx_pkg::CH_UNDER;
    return 8'("0" + (i - 53));
  endfunction

  function automatic logic [7:0] pick_number_char();
    int i;
    i = $urandom_range(0, 10);
    return (i == 10) ? slx_pkg::CH_DOT : 8'("0" + i);
  endfunction

  function automatic logic [7:0] pick_string_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: c = ($urandom_range(0, 1) != 0) ? slx_pkg::CH_CR : slx_pkg::CH_LF;
      1: c = 8'($urandom_range(0, 255));
      default: c = 8'($urandom_range(32'h20, 32'h7e));
    endcase
    if (c == slx_pkg::CH_QUOTE || c == slx_pkg::CH_BACKSLASH)
      c = "s";
    return c;
  endfunction

  function automatic logic [7:0] pick_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (board.is_known(c));
    return c;
  endfunction

  // one text of random tokens, ended by an end-of-input transfer
  task automatic lex_text();
    string      punct_set;
    string      blank_set;
    int         n_tok;
    int         r;
    logic [7:0] c;
    bit         dead;
    punct_set = "+-*/%=(){}><,$:[];";
    blank_set = " \t\r\n";
    dead = 1'b0;
    n_tok = $urandom_range(1, 20);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        send(pick_word_char(1'b0), 1'b0);
        repeat ($urandom_range(0, 7)) send(pick_word_char(1'b1), 1'b0);
      end else if (r < 40) begin
        repeat ($urandom_range(1, 6)) send(pick_number_char(), 1'b0);
      end else if (r < 58) begin
        send(slx_pkg::CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 5) == 0) begin
            send(slx_pkg::CH_BACKSLASH, 1'b0);
            send(($urandom_range(0, 1) != 0) ? slx_pkg::CH_LOWER_R : slx_pkg::CH_LOWER_N,
                 1'b0);
          end else begin
            send(pick_string_char(), 1'b0);
          end
        end
        send(slx_pkg::CH_QUOTE, 1'b0);
      end else if (r < 73) begin
        send(punct_set[$urandom_range(0, punct_set.len() - 1)], 1'b0);
      end else if (r < 94) begin
        send(blank_set[$urandom_range(0, 3)], 1'b0);
      end else if (r < 97) begin
        // bad escape, a quote after the backslash included
        send(slx_pkg::CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 2)) send(pick_string_char(), 1'b0);
        send(slx_pkg::CH_BACKSLASH, 1'b0);
        do c = 8'($urandom_range(0, 255));
        while (c == slx_pkg::CH_LOWER_R || c == slx_pkg::CH_LOWER_N);
        send(c, 1'b0);
        dead = 1'b1;
        break;
      end else begin
        send(pick_unknown(), 1'b0);
        dead = 1'b1;
        break;
      end
    end
    if (dead) begin
      repeat ($urandom_range(0, 3)) send(8'($urandom_range(0, 255)), 1'b0);
    end else if ($urandom_range(0, 9) < 2) begin
      // text cut off inside a string, sometimes right after a backslash
      send(slx_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 3)) send(pick_string_char(), 1'b0);
      if ($urandom_range(0, 1) != 0)
        send(slx_pkg::CH_BACKSLASH, 1'b0);
    end
    send(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    logic [7:0] opening [0:19];
    opening = '{"a", slx_pkg::CH_UNDER, "Z", "9", slx_pkg::CH_SPACE, "0", slx_pkg::CH_DOT,
                "+", slx_pkg::CH_TAB, slx_pkg::CH_QUOTE, slx_pkg::CH_QUOTE, slx_pkg::CH_CR,
                slx_pkg::CH_QUOTE, slx_pkg::CH_BACKSLASH, slx_pkg::CH_LOWER_R,
                slx_pkg::CH_BACKSLASH, slx_pkg::CH_LOWER_N, 8'h00, 8'hff,
                slx_pkg::CH_QUOTE};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: every token kind, escapes, zero and high bytes in a string,
    // empty string, open string and dangling backslash at end, unknown byte
    foreach (opening[i]) send(opening[i], 1'b0);
    send(8'hff, 1'b1);
    send(slx_pkg::CH_QUOTE, 1'b0);
    send(8'h00, 1'b1);
    send(slx_pkg::CH_QUOTE, 1'b0);
    send(slx_pkg::CH_BACKSLASH, 1'b0);
    send(8'h5a, 1'b1);
    send(8'h80, 1'b0);
    send("x", 1'b0);
    send(8'h7f, 1'b1);

    while (board.live_items < 1950) lex_text();
    s_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("lexed %0d live bytes over %0d texts with bursty input and stalled output",
             board.live_items, board.texts);
    $display("results: ident %0d number %0d string %0d punct %0d end %0d error %0d",
             board.kind_seen[0], board.kind_seen[1], board.kind_seen[2],
             board.kind_seen[3], board.kind_seen[4], board.kind_seen[5]);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
